// ----- rtl/core/rti_pkg.sv -----
// Shared types, widths and codes for the ray/triangle intersection block.
// No dependencies; every other file in rtl/core imports this package.
package rti_pkg;

    localparam int COORD_W           = 32;
    localparam int DIFF_W            = COORD_W + 1;
    localparam int PROD_W            = 2 * DIFF_W;
    localparam int CROSS_W           = PROD_W + 1;
    localparam int LO_W              = DIFF_W + 1;
    localparam int HI_W              = CROSS_W - LO_W;
    localparam int PLO_W             = DIFF_W + LO_W + 1;
    localparam int DOT_W             = DIFF_W + CROSS_W + 2;
    localparam int QBITS             = COORD_W + 1;
    localparam int CFG_IDX_W         = 3;
    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int QUEUE_DEPTH       = 4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [PLO_W-1:0]   plo_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    typedef enum logic [2:0] {
        OUT_HIT      = 3'd0,
        OUT_PARALLEL = 3'd1,
        OUT_U_OUT    = 3'd2,
        OUT_V_OUT    = 3'd3,
        OUT_BEHIND   = 3'd4
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_t;

    // Word passed from classifier to divider; cls of OUT_HIT marks a candidate.
    typedef struct packed {
        outcome_t cls;
        dot_t     a;
        dot_t     tn;
    } job_t;

    function automatic diff_t dsub(coord_t x, coord_t y);
        diff_t r;
        r = {x[COORD_W-1], x} - {y[COORD_W-1], y};
        return r;
    endfunction

    function automatic diff_t dext(coord_t x);
        diff_t r;
        r = {x[COORD_W-1], x};
        return r;
    endfunction

endpackage

// ----- rtl/core/ray_triangle_intersect.sv -----
// Top level of the ray/triangle intersection block: ray registers and wiring.
// Depends on rti_pkg, rti_front, rti_queue and rti_back.
//
// Takes one triangle per clock while in_ready is high; returns one word per
// triangle, in order: hit flag, outcome code and the distance t along the ray
// in signed fixed point with COORD_FRAC_BITS fraction bits, saturated. Each
// triangle passes the edge, cross product, dot product and test stages, the
// queue, then the divider (one quotient bit per stage, 33 bits) and output
// register. The user must write the ray origin and direction through the cfg
// port only while no triangle is in flight; the block does not enforce this.
// Index 0..5 selects origin x,y,z then direction x,y,z.
module ray_triangle_intersect
    import rti_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coord_t               cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  coord_t               v0_x,
    input  coord_t               v0_y,
    input  coord_t               v0_z,
    input  coord_t               v1_x,
    input  coord_t               v1_y,
    input  coord_t               v1_z,
    input  coord_t               v2_x,
    input  coord_t               v2_y,
    input  coord_t               v2_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic [2:0]           outcome,
    output coord_t               hit_distance
);

    localparam coord_t ONE = coord_t'(1) <<< COORD_FRAC_BITS;

    coord_t   org_reg [3];
    coord_t   dir_reg [3];
    coord_t   v0 [3], v1 [3], v2 [3];
    logic     job_f_valid, job_f_ready, job_b_valid, job_b_ready;
    job_t     job_f, job_b;
    outcome_t outcome_w;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg <= '{'0, '0, '0};
            dir_reg <= '{'0, '0, ONE};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data;
                REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                REG_DIR_X:    dir_reg[0] <= cfg_data;
                REG_DIR_Y:    dir_reg[1] <= cfg_data;
                REG_DIR_Z:    dir_reg[2] <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign v0 = '{v0_x, v0_y, v0_z};
    assign v1 = '{v1_x, v1_y, v1_z};
    assign v2 = '{v2_x, v2_y, v2_z};

    rti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .v0        (v0),
        .v1        (v1),
        .v2        (v2),
        .org       (org_reg),
        .dir       (dir_reg),
        .job_valid (job_f_valid),
        .job_ready (job_f_ready),
        .job       (job_f)
    );

    rti_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_f_valid),
        .push_ready (job_f_ready),
        .push_word  (job_f),
        .pop_valid  (job_b_valid),
        .pop_ready  (job_b_ready),
        .pop_word   (job_b)
    );

    rti_back #(.FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_b_valid),
        .job_ready    (job_b_ready),
        .job          (job_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .outcome      (outcome_w),
        .hit_distance (hit_distance)
    );

    assign outcome = outcome_w;

    a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (outcome == OUT_HIT)))
        else $error("hit flag disagrees with outcome");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_PARALLEL || outcome == OUT_U_OUT ||
                      outcome == OUT_V_OUT) |-> (hit_distance == '0))
        else $error("distance not zero on a miss");

    a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_HIT) |-> (hit_distance > 0))
        else $error("hit with non-positive distance");

    a_behind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_BEHIND) |-> !(hit_distance > 0))
        else $error("behind-origin outcome with positive distance");

endmodule

// ----- rtl/core/rti_front.sv -----
// Front pipeline: edges, cross products, determinant and barycentric tests.
// Depends on rti_pkg; emits one job_t word per triangle towards the queue.
module rti_front
    import rti_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t v0 [3],
    input  coord_t v1 [3],
    input  coord_t v2 [3],
    input  coord_t org [3],
    input  coord_t dir [3],
    output logic   job_valid,
    input  logic   job_ready,
    output job_t   job
);

    localparam int NSTG = 9;

    logic [NSTG-1:0] vld_reg;
    logic            adv;

    diff_t  dx [3];
    diff_t  e1_s1_next [3], e2_s1_next [3], s_s1_next [3];
    diff_t  e1_s1_reg [3],  e2_s1_reg [3],  s_s1_reg [3];
    prod_t  hp_next [3][2], qp_next [3][2];
    prod_t  hp_reg [3][2],  qp_reg [3][2];
    diff_t  e1_s2_reg [3],  e2_s2_reg [3],  s_s2_reg [3];
    cross_t h_next [3], q_next [3];
    cross_t h_reg [3],  q_reg [3];
    diff_t  e1_s3_reg [3],  e2_s3_reg [3],  s_s3_reg [3];
    plo_t   plo_next [4][3], plo_reg [4][3];
    prod_t  phi_next [4][3], phi_reg [4][3];
    dot_t   term_next [4][3], term_reg [4][3];
    dot_t   dot_next [4], dot_reg [4];
    dot_t   nrm_next [4], nrm_reg [4];
    logic   a_zero_next, u_out_next, vn_neg_next;
    logic   a_zero_reg,  u_out_reg,  vn_neg_reg;
    logic signed [DOT_W:0] uv_next, uv_reg;
    dot_t   a8_reg, tn8_reg;
    job_t   job_next, job_reg;

    assign adv      = !vld_reg[NSTG-1] || job_ready;
    assign in_ready = adv;

    always_comb
    begin
        int j;
        int k;
        diff_t  xs [4][3];
        cross_t ys [4][3];
        for (int i = 0; i < 3; i++)
        begin
            dx[i]         = dext(dir[i]);
            e1_s1_next[i] = dsub(v1[i], v0[i]);
            e2_s1_next[i] = dsub(v2[i], v0[i]);
            s_s1_next[i]  = dsub(org[i], v0[i]);
        end
        // h = dir x e2, q = s x e1
        for (int i = 0; i < 3; i++)
        begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            hp_next[i][0] = dx[j] * e2_s1_reg[k];
            hp_next[i][1] = dx[k] * e2_s1_reg[j];
            qp_next[i][0] = s_s1_reg[j] * e1_s1_reg[k];
            qp_next[i][1] = s_s1_reg[k] * e1_s1_reg[j];
            h_next[i] = CROSS_W'(hp_reg[i][0]) - CROSS_W'(hp_reg[i][1]);
            q_next[i] = CROSS_W'(qp_reg[i][0]) - CROSS_W'(qp_reg[i][1]);
        end
        // a = e1.h, un = s.h, vn = dir.q, tn = e2.q; split the wide factor
        for (int i = 0; i < 3; i++)
        begin
            xs[0][i] = e1_s3_reg[i]; ys[0][i] = h_reg[i];
            xs[1][i] = s_s3_reg[i];  ys[1][i] = h_reg[i];
            xs[2][i] = dx[i];        ys[2][i] = q_reg[i];
            xs[3][i] = e2_s3_reg[i]; ys[3][i] = q_reg[i];
        end
        for (int d = 0; d < 4; d++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                plo_next[d][i]  = xs[d][i] * $signed({1'b0, ys[d][i][LO_W-1:0]});
                phi_next[d][i]  = xs[d][i] * $signed(ys[d][i][CROSS_W-1:LO_W]);
                term_next[d][i] = (DOT_W'(phi_reg[d][i]) <<< LO_W) + DOT_W'(plo_reg[d][i]);
            end
            dot_next[d] = term_reg[d][0] + term_reg[d][1] + term_reg[d][2];
            // flip all four so the determinant is not negative
            nrm_next[d] = dot_reg[0][DOT_W-1] ? -dot_reg[d] : dot_reg[d];
        end
        a_zero_next = (nrm_reg[0] == '0);
        u_out_next  = nrm_reg[1][DOT_W-1] || (nrm_reg[1] > nrm_reg[0]);
        vn_neg_next = nrm_reg[2][DOT_W-1];
        uv_next     = (DOT_W+1)'(nrm_reg[1]) + (DOT_W+1)'(nrm_reg[2]);

        job_next.a  = a8_reg;
        job_next.tn = tn8_reg;
        if (a_zero_reg)
            job_next.cls = OUT_PARALLEL;
        else if (u_out_reg)
            job_next.cls = OUT_U_OUT;
        else if (vn_neg_reg || (uv_reg > (DOT_W+1)'(a8_reg)))
            job_next.cls = OUT_V_OUT;
        else
            job_next.cls = OUT_HIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_s1_reg <= e1_s1_next;
            e2_s1_reg <= e2_s1_next;
            s_s1_reg  <= s_s1_next;
            hp_reg    <= hp_next;
            qp_reg    <= qp_next;
            e1_s2_reg <= e1_s1_reg;
            e2_s2_reg <= e2_s1_reg;
            s_s2_reg  <= s_s1_reg;
            h_reg     <= h_next;
            q_reg     <= q_next;
            e1_s3_reg <= e1_s2_reg;
            e2_s3_reg <= e2_s2_reg;
            s_s3_reg  <= s_s2_reg;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            term_reg  <= term_next;
            dot_reg   <= dot_next;
            nrm_reg   <= nrm_next;
            a_zero_reg <= a_zero_next;
            u_out_reg  <= u_out_next;
            vn_neg_reg <= vn_neg_next;
            uv_reg     <= uv_next;
            a8_reg     <= nrm_reg[0];
            tn8_reg    <= nrm_reg[3];
            job_reg    <= job_next;
        end
    end

    assign job_valid = vld_reg[NSTG-1];
    assign job       = job_reg;

endmodule

// ----- rtl/core/rti_queue.sv -----
// Short FIFO of job_t words between the classifier and the divider.
// Depends on rti_pkg for job_t.
module rti_queue
    import rti_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_word,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

endmodule

// ----- rtl/core/rti_back.sv -----
// Back pipeline: restoring division for t, one quotient bit per stage,
// then saturation and the final outcome. Depends on rti_pkg.
module rti_back
    import rti_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  job_t     job,
    output logic     out_valid,
    input  logic     out_ready,
    output logic     hit,
    output outcome_t outcome,
    output coord_t   hit_distance
);

    localparam int NW   = DOT_W + FRAC_BITS;
    localparam int XW   = NW + QBITS;
    localparam int NSTG = QBITS + 2;
    localparam coord_t T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [NSTG-1:0]  vld_reg;
    logic             adv;
    logic [XW-1:0]    r_next [NSTG], r_reg [NSTG];
    logic [XW-1:0]    a_next [NSTG], a_reg [NSTG];
    logic [QBITS-1:0] q_next [NSTG], q_reg [NSTG];
    logic             big_next [NSTG], big_reg [NSTG];
    logic             neg_next [NSTG], neg_reg [NSTG];
    outcome_t         cls_next [NSTG], cls_reg [NSTG];
    logic [DOT_W-1:0] mag;
    logic             out_vld_reg, hit_reg, hit_next;
    outcome_t         outcome_reg, outcome_next;
    coord_t           dist_reg, dist_next;
    logic [QBITS-1:0] qf;
    logic             sat;
    coord_t           t;

    assign adv       = !out_vld_reg || out_ready;
    assign job_ready = adv;

    always_comb
    begin
        int k;
        mag         = job.tn[DOT_W-1] ? DOT_W'(-job.tn) : DOT_W'(job.tn);
        r_next[0]   = XW'(mag) << FRAC_BITS;
        a_next[0]   = XW'($unsigned(job.a));
        q_next[0]   = '0;
        big_next[0] = 1'b0;
        neg_next[0] = job.tn[DOT_W-1];
        cls_next[0] = job.cls;

        // quotient wider than its field: saturate
        r_next[1]   = r_reg[0];
        a_next[1]   = a_reg[0];
        q_next[1]   = '0;
        big_next[1] = (r_reg[0] >= (a_reg[0] << QBITS));
        neg_next[1] = neg_reg[0];
        cls_next[1] = cls_reg[0];

        for (int s = 2; s < NSTG; s++)
        begin
            k           = NSTG - 1 - s;
            a_next[s]   = a_reg[s-1];
            big_next[s] = big_reg[s-1];
            neg_next[s] = neg_reg[s-1];
            cls_next[s] = cls_reg[s-1];
            if (r_reg[s-1] >= (a_reg[s-1] << k))
            begin
                r_next[s] = r_reg[s-1] - (a_reg[s-1] << k);
                q_next[s] = q_reg[s-1] | (QBITS'(1) << k);
            end
            else
            begin
                r_next[s] = r_reg[s-1];
                q_next[s] = q_reg[s-1];
            end
        end

        qf = q_reg[NSTG-1];
        if (neg_reg[NSTG-1])
        begin
            sat = big_reg[NSTG-1] || qf[QBITS-1] ||
                  (qf[COORD_W-1] && (qf[COORD_W-2:0] != '0));
            t   = sat ? T_MIN : coord_t'('0 - qf[COORD_W-1:0]);
        end
        else
        begin
            sat = big_reg[NSTG-1] || qf[QBITS-1] || qf[COORD_W-1];
            t   = sat ? T_MAX : coord_t'(qf[COORD_W-1:0]);
        end

        if (cls_reg[NSTG-1] == OUT_HIT)
        begin
            outcome_next = (t > 0) ? OUT_HIT : OUT_BEHIND;
            dist_next    = t;
        end
        else
        begin
            outcome_next = cls_reg[NSTG-1];
            dist_next    = '0;
        end
        hit_next = (outcome_next == OUT_HIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NSTG-2:0], job_valid};
            out_vld_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg       <= r_next;
            a_reg       <= a_next;
            q_reg       <= q_next;
            big_reg     <= big_next;
            neg_reg     <= neg_next;
            cls_reg     <= cls_next;
            hit_reg     <= hit_next;
            outcome_reg <= outcome_next;
            dist_reg    <= dist_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign hit          = hit_reg;
    assign outcome      = outcome_reg;
    assign hit_distance = dist_reg;

endmodule

// ----- tb/ray_triangle_intersect_checker.sv -----
// Checker for ray_triangle_intersect: watches the cfg, triangle and result channels,
// predicts each result word and compares it field by field. Depends on rti_pkg.
module ray_triangle_intersect_checker
    import rti_pkg::*;
#(
    parameter int FRAC = DEFAULT_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coord_t               cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  coord_t               v0_x,
    input  coord_t               v0_y,
    input  coord_t               v0_z,
    input  coord_t               v1_x,
    input  coord_t               v1_y,
    input  coord_t               v1_z,
    input  coord_t               v2_x,
    input  coord_t               v2_y,
    input  coord_t               v2_z,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 hit,
    input  logic [2:0]           outcome,
    input  coord_t               hit_distance,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] big_t;

    typedef struct packed {
        logic     hit;
        outcome_t code;
        coord_t   tval;
    } verdict_t;

    coord_t   ray_org [3];
    coord_t   ray_dir [3];
    verdict_t verdicts_due [$];

    function automatic verdict_t intersect_triangle(coord_t vx [9]);
        big_t e1 [3];
        big_t e2 [3];
        big_t s [3];
        big_t d [3];
        big_t h [3];
        big_t q [3];
        big_t a, un, vn, tn, mag, quo;
        logic signed [63:0] t;
        verdict_t r;
        t = 0;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = big_t'(vx[3+i]) - big_t'(vx[i]);
            e2[i] = big_t'(vx[6+i]) - big_t'(vx[i]);
            s[i]  = big_t'(ray_org[i]) - big_t'(vx[i]);
            d[i]  = big_t'(ray_dir[i]);
        end
        h[0] = d[1]*e2[2] - d[2]*e2[1];
        h[1] = d[2]*e2[0] - d[0]*e2[2];
        h[2] = d[0]*e2[1] - d[1]*e2[0];
        a = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
        if (a == 0)
            r.code = OUT_PARALLEL;
        else
        begin
            q[0] = s[1]*e1[2] - s[2]*e1[1];
            q[1] = s[2]*e1[0] - s[0]*e1[2];
            q[2] = s[0]*e1[1] - s[1]*e1[0];
            un = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
            vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
            tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
            if (a < 0)
            begin
                a = -a; un = -un; vn = -vn; tn = -tn;
            end
            if (un < 0 || un > a)
                r.code = OUT_U_OUT;
            else if (vn < 0 || un + vn > a)
                r.code = OUT_V_OUT;
            else
            begin
                mag = (tn < 0) ? -tn : tn;
                quo = (mag <<< FRAC) / a;
                if (tn < 0)
                    t = (quo > big_t'(64'sh80000000)) ? -64'sh80000000 : -64'(quo);
                else
                    t = (quo > big_t'(64'sh7fffffff)) ? 64'sh7fffffff : 64'(quo);
                r.code = (t > 0) ? OUT_HIT : OUT_BEHIND;
            end
        end
        r.hit  = (r.code == OUT_HIT);
        r.tval = coord_t'(t);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            ray_org = '{0, 0, 0};
            ray_dir = '{0, 0, 65536};
            verdicts_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ORIGIN_X: ray_org[0] = cfg_data;
                    REG_ORIGIN_Y: ray_org[1] = cfg_data;
                    REG_ORIGIN_Z: ray_org[2] = cfg_data;
                    REG_DIR_X:    ray_dir[0] = cfg_data;
                    REG_DIR_Y:    ray_dir[1] = cfg_data;
                    REG_DIR_Z:    ray_dir[2] = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                verdicts_due.push_back(intersect_triangle(
                    '{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z}));
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        fail_count++;
                    end
                    if (outcome !== want.code)
                    begin
                        $error("outcome: expected %0d, got %0d", want.code, outcome);
                        fail_count++;
                    end
                    if (hit_distance !== want.tval)
                    begin
                        $error("hit_distance: expected %0d, got %0d", want.tval,
                            hit_distance);
                        fail_count++;
                    end
                end
            end
            pending = verdicts_due.size();
        end
    end
endmodule

// ----- tb/ray_triangle_intersect_test.sv -----
// Top of the ray_triangle_intersect testbench: clock, reset, ray setup and triangle stream.
// Depends on rti_pkg, the block and ray_triangle_intersect_checker.
module ray_triangle_intersect_test;
    import rti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 46;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ORIGIN_X;
    coord_t               cfg_data = 0;
    logic                 in_valid = 0;
    logic                 in_ready;
    coord_t               tri_v [9] = '{default: 0};
    logic                 out_valid;
    logic                 out_ready = 0;
    logic                 hit;
    logic [2:0]           outcome;
    coord_t               hit_distance;
    int                   fail_count;
    int                   pending;
    int                   cycles = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    ray_triangle_intersect dut (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid, .in_ready,
        .v0_x(tri_v[0]), .v0_y(tri_v[1]), .v0_z(tri_v[2]),
        .v1_x(tri_v[3]), .v1_y(tri_v[4]), .v1_z(tri_v[5]),
        .v2_x(tri_v[6]), .v2_y(tri_v[7]), .v2_z(tri_v[8]),
        .out_valid, .out_ready, .hit, .outcome, .hit_distance
    );

    ray_triangle_intersect_checker chk (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid, .in_ready,
        .v0_x(tri_v[0]), .v0_y(tri_v[1]), .v0_z(tri_v[2]),
        .v1_x(tri_v[3]), .v1_y(tri_v[4]), .v1_z(tri_v[5]),
        .v2_x(tri_v[6]), .v2_y(tri_v[7]), .v2_z(tri_v[8]),
        .out_valid, .out_ready, .hit, .outcome, .hit_distance,
        .fail_count, .pending
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stall per word, with no stall on some words.
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap != 0)
            begin
                out_ready = 0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic write_reg(cfg_reg_t idx, coord_t val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_ray(coord_t ox, coord_t oy, coord_t oz,
                           coord_t dx, coord_t dy, coord_t dz);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Hold valid and payload until the word is taken.
    task automatic send_triangle(coord_t vx [9], bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        repeat (gap) @(negedge clk);
        tri_v    = vx;
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 0;
    endtask

    function automatic coord_t pick_coord(int span);
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return coord_t'($urandom());
            default: return coord_t'($signed($urandom_range(0, 2*span)) - span);
        endcase
    endfunction

    // Random triangle, coordinates mostly in -span..span, now and then extreme.
    task automatic send_random(int span, bit calm);
        coord_t vx [9];
        for (int i = 0; i < 9; i++)
            vx[i] = ($urandom_range(0, 7) == 0) ? pick_coord(span)
                  : coord_t'($signed($urandom_range(0, 2*span)) - span);
        send_triangle(vx, calm);
    endtask

    initial
    begin
        coord_t one;
        one = 65536;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: reset ray (down +z from origin).
        send_triangle('{-one, -one, one, 2*one, -one, one, -one, 2*one, one}, 0); // hit
        send_triangle('{-one, -one, -one, 2*one, -one, -one, -one, 2*one, -one}, 0); // behind
        send_triangle('{0, 0, 0, one, 0, 0, 2*one, 0, 0}, 0); // parallel, degenerate
        send_triangle('{-one, -one, one, 2*one, -one, one, -one, 2*one, 2*one}, 0);
        send_triangle('{one, one, one, 3*one, one, one, one, 3*one, one}, 0); // u/v outside
        send_triangle('{-one, 0, one, -one, one, one, -2*one, 0, one}, 0);
        send_triangle('{-one, -one, 0, 2*one, -one, 0, -one, 2*one, 0}, 0); // t zero
        send_triangle('{-one, -one, 1, one, -one, 1, -one, one, 1}, 0); // tiny t
        send_triangle('{0, 0, 32'sh7fffffff, 1, 0, 32'sh7fffffff, 0, 1, 32'sh7fffffff}, 0);
        send_triangle('{32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                        32'sh80000000, 32'sh7fffffff, 32'sh7fffffff}, 0);
        send_triangle('{-1, -1, 32'sh7fffffff, 1, -1, 32'sh7fffffff, -1, 1, 32'sh80000000}, 0);
        send_triangle('{default: -1}, 0);
        drain();

        // Extreme ray: tiny direction gives saturated t.
        set_ray(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1, -1, 1);
        send_triangle('{0, 0, 0, -one, 0, 0, 0, one, 0}, 0);
        send_triangle('{32'sh7fffffff, 32'sh80000000, 100, 32'sh7fffffff, 0,
                        100, 0, 32'sh80000000, 100}, 0);
        send_triangle('{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                        32'sh80000000, 32'sh80000000, 32'sh80000000}, 0);
        drain();
        set_ray(0, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_triangle('{one, 0, 0, 0, one, 0, 0, 0, one}, 0);
        send_triangle('{-one, 0, 0, 0, one, 0, 0, 0, -one}, 0);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            int span;
            span = (phase % 3 == 0) ? 4 * 65536 : ((phase % 3 == 1) ? 256 : 1 << 30);
            if (phase == 5)
                set_ray(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
                        coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()));
            else
                set_ray(coord_t'($signed($urandom_range(0, 2*span)) - span),
                        coord_t'($signed($urandom_range(0, 2*span)) - span),
                        coord_t'($signed($urandom_range(0, 2*span)) - span),
                        coord_t'($signed($urandom_range(0, 2*span)) - span),
                        coord_t'($signed($urandom_range(0, 2*span)) - span),
                        coord_t'($signed($urandom_range(0, 2*span)) - span));
            for (int n = 0; n < 140; n++)
            begin
                // Pause until all results are back, once per phase.
                if (n == 70)
                    while (pending != 0) @(negedge clk);
                send_random(span, n >= 100 && n < 120);
            end
            drain();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/rti_pkg.sv
rtl/core/rti_front.sv
rtl/core/rti_queue.sv
rtl/core/rti_back.sv
rtl/core/ray_triangle_intersect.sv
tb/ray_triangle_intersect_checker.sv
tb/ray_triangle_intersect_test.sv
